>>> rtl/plr_pkg.sv
`timescale 1ns / 1ps
package plr_pkg;

  localparam int unsigned ChannelsDefault = 128;
  localparam int unsigned MaxRunDefault   = 64;

  localparam logic [7:0]  ChannelCountReset = 8'd128;
  localparam logic [31:0] GridStepReset     = 32'h0001_0000;

  typedef enum logic [1:0] {
    StatusOk        = 2'd0,
    StatusBadChan   = 2'd1,
    StatusTruncated = 2'd2
  } status_e;

  typedef enum logic {
    RegChannelCount = 1'b0,
    RegGridStep     = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [7:0]  channel;
    logic [31:0] sample_time;
    logic [31:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_channel;
    logic [31:0] grid_index;
    logic [31:0] grid_value;
    logic        last;
    logic [1:0]  status;
  } out_item_t;

  // Operands of one interpolation; the divider takes these.
  typedef struct packed {
    logic [47:0] a;     // |t - T0|, Q32.16
    logic [31:0] b;     // |y1 - y0|
    logic [47:0] d;     // |T1 - T0|, Q32.16
    logic        neg;
    logic [31:0] y0;
  } lerp_req_t;

endpackage

>>> rtl/plr_lerp.sv
`timescale 1ns / 1ps
// Interpolation unit: 48x32 product in two 24x32 partial products, then a
// restoring divide, one quotient bit a cycle over 80 significant bits
// (product < 2^80), quotient saturated at 2^40, then signed add and clamp.
module plr_lerp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  plr_pkg::lerp_req_t req_i,
  output logic               done_o,
  output logic [31:0]        value_o
);

  localparam int unsigned PW = 80;

  typedef enum logic [2:0] {
    SIdle, SMul0, SMul1, SDiv, SFin
  } state_e;

  state_e           state_q;
  plr_pkg::lerp_req_t req_q;
  logic [PW-1:0]    prod_q;
  logic [55:0]      part_q;
  logic [48:0]      rem_q;
  logic [40:0]      quo_q;
  logic             sat_q;
  logic [6:0]       cnt_q;
  logic             done_q;
  logic [31:0]      value_q;

  logic [48:0] rem_sh;
  logic        qb;
  logic [40:0] quo_nx;
  logic [33:0] mag;
  logic [34:0] sum;

  assign rem_sh = {rem_q[47:0], prod_q[PW-1]};
  assign qb     = rem_sh >= {1'b0, req_q.d};
  assign quo_nx = {quo_q[39:0], qb};
  // q stops growing once it reaches 2^40; the clamp below only needs 34 bits of it.
  assign mag    = (sat_q || quo_q[40]) ? 34'h3_0000_0000 :
                  (|quo_q[39:33]) ? 34'h3_0000_0000 : {1'b0, quo_q[32:0]};
  assign sum    = req_q.neg ? ({3'b0, req_q.y0} - {1'b0, mag})
                            : ({3'b0, req_q.y0} + {1'b0, mag});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        SIdle: begin
          if (start_i) begin
            req_q   <= req_i;
            state_q <= SMul0;
          end
        end
        SMul0: begin
          part_q  <= 56'(req_q.a[23:0]) * 56'(req_q.b);
          state_q <= SMul1;
        end
        SMul1: begin
          prod_q  <= PW'({56'(req_q.a[47:24]) * 56'(req_q.b), 24'b0}) + PW'(part_q);
          rem_q   <= '0;
          quo_q   <= '0;
          sat_q   <= 1'b0;
          cnt_q   <= 7'(PW - 1);
          state_q <= SDiv;
        end
        SDiv: begin
          rem_q  <= qb ? rem_sh - {1'b0, req_q.d} : rem_sh;
          prod_q <= {prod_q[PW-2:0], 1'b0};
          if (!sat_q) begin
            quo_q <= quo_nx;
            if (quo_nx[40]) sat_q <= 1'b1;
          end
          cnt_q <= cnt_q - 7'd1;
          if (cnt_q == '0) state_q <= SFin;
        end
        SFin: begin
          if (sum[34]) value_q <= '0;
          else if (|sum[33:32]) value_q <= '1;
          else value_q <= sum[31:0];
          done_q  <= 1'b1;
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign done_o  = done_q;
  assign value_o = value_q;

  a_done_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SFin) |=> done_q)
    else $error("done missing after finish");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == SIdle))
    else $error("done while busy");
  a_sat_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SDiv && sat_q) |=> (sat_q || state_q != SDiv))
    else $error("saturation dropped");

endmodule

>>> rtl/plr_state_mem.sv
`timescale 1ns / 1ps
// Per-channel state memory: {next index, previous value, previous time},
// one read port with registered data, one write port. A clearing pass after
// reset zeroes every entry.
module plr_state_mem #(
  parameter int unsigned Channels = plr_pkg::ChannelsDefault,
  localparam int unsigned AW = (Channels > 1) ? $clog2(Channels) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [95:0]   rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [95:0]   wr_data_i,
  output logic          clearing_o
);

  logic [95:0]   mem [Channels];
  logic [AW-1:0] clr_addr_q;
  logic          clearing_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(Channels - 1)) clearing_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) mem[clr_addr_q] <= '0;
    else if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
    if (rd_en_i) rd_data_o <= mem[rd_addr_i];
  end

  assign clearing_o = clearing_q;

endmodule

>>> rtl/per_channel_linear_resampler.sv
`timescale 1ns / 1ps
// Per-channel linear resampler.
// Input channel (in_valid_i/in_ready_o/in_item_i): one sample (channel,
// integer time, Q16.16 value). Output channel (out_valid_o/out_ready_i/
// out_item_o): zero to MaxRun grid points per sample, in ascending index
// order, the final one marked last. A channel at or above channel_count
// (or at or above Channels) gives one result with status 1 and changes nothing.
// Sequence: a sample is read from the state memory (SRead), then each grid
// point is compared (SCheck), worked out in the shared interpolation unit
// (multiply, 80 divide steps, finish, hand-back) and emitted (SEmit);
// then the channel state is written back (SWrite). Points on equal times
// skip the interpolation unit. One sample is worked on at a time; a sample
// with no point due goes from compare straight to write-back, and an
// out-of-range channel returns to idle from the read.
// Reset: registers go to channel_count 128, grid_step 1.0; a clearing
// pass zeroes the state memory while in_ready_o is low.
// A stalled receiver holds the result in the output register and the
// sequencer waits; nothing is dropped.
module per_channel_linear_resampler #(
  parameter int unsigned Channels = plr_pkg::ChannelsDefault,
  parameter int unsigned MaxRun   = plr_pkg::MaxRunDefault,
  localparam int unsigned AW = (Channels > 1) ? $clog2(Channels) : 1,
  localparam int unsigned RW = $clog2(MaxRun + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  plr_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output plr_pkg::out_item_t out_item_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [2:0] {
    SIdle, SRead, SCheck, SLerp, SEmit, SWrite
  } state_e;

  state_e            state_q;
  plr_pkg::in_item_t item_q;
  logic [7:0]        chan_cnt_q;
  logic [31:0]       step_q;
  logic [31:0]       idx_q, t0_q, y0_q;
  logic [31:0]       val_q;      // value of the point being worked on
  logic [RW-1:0]     n_q;
  logic              out_valid_q;
  plr_pkg::out_item_t out_q;
  logic              pt_due;     // grid time of idx_q is due
  logic [63:0]       gt_q;       // grid time of idx_q

  logic [95:0] rd_data;
  logic        clearing;
  logic        lerp_start, lerp_done;
  logic [31:0] lerp_value;
  plr_pkg::lerp_req_t lerp_req;

  // APB
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    unique case (plr_pkg::reg_idx_e'(paddr[2]))
      plr_pkg::RegChannelCount: prdata = {24'b0, chan_cnt_q};
      plr_pkg::RegGridStep:     prdata = step_q;
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cnt_q <= plr_pkg::ChannelCountReset;
      step_q     <= plr_pkg::GridStepReset;
    end else if (psel && penable && pwrite) begin
      unique case (plr_pkg::reg_idx_e'(paddr[2]))
        plr_pkg::RegChannelCount: chan_cnt_q <= pwdata[7:0];
        plr_pkg::RegGridStep:     step_q     <= pwdata;
        default: ;
      endcase
    end
  end

  logic bad_chan;
  assign bad_chan = ({1'b0, item_q.channel} >= {1'b0, chan_cnt_q}) ||
                    (9'(item_q.channel) >= 9'(Channels));

  // Load the output register only when it is empty or draining
  logic out_free, out_load;
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = out_free && ((state_q == SRead && bad_chan) || state_q == SEmit);

  logic [63:0] big1;
  assign big1 = {16'b0, item_q.sample_time, 16'b0};

  // Interpolation operands for current grid time gt_q
  logic [47:0] big0;
  assign big0 = {t0_q, 16'b0};
  always_comb begin
    lerp_req.a   = (gt_q[47:0] >= big0 && gt_q[63:48] == '0) ? 48'(gt_q - 64'(big0))
                                                               : 48'(64'(big0) - gt_q);
    lerp_req.neg = !(gt_q >= 64'(big0));
    lerp_req.b   = (item_q.sample_value >= y0_q) ? item_q.sample_value - y0_q
                                                 : y0_q - item_q.sample_value;
    if (item_q.sample_value < y0_q) lerp_req.neg = !lerp_req.neg;
    lerp_req.d   = (item_q.sample_time > t0_q) ? {item_q.sample_time - t0_q, 16'b0}
                                               : {t0_q - item_q.sample_time, 16'b0};
    lerp_req.y0  = y0_q;
  end
  // gt_q <= big1 < 2^48 whenever a point is due, so the 48-bit a is exact.

  assign lerp_start = (state_q == SCheck) && pt_due && (n_q != RW'(MaxRun)) &&
                      (t0_q != item_q.sample_time);

  plr_lerp u_lerp (
    .clk_i, .rst_ni,
    .start_i (lerp_start),
    .req_i   (lerp_req),
    .done_o  (lerp_done),
    .value_o (lerp_value)
  );

  plr_state_mem #(.Channels(Channels)) u_mem (
    .clk_i, .rst_ni,
    .rd_en_i    (state_q == SIdle),
    .rd_addr_i  (in_item_i.channel[AW-1:0]),
    .rd_data_o  (rd_data),
    .wr_en_i    (state_q == SWrite),
    .wr_addr_i  (item_q.channel[AW-1:0]),
    .wr_data_i  ({idx_q, item_q.sample_value, item_q.sample_time}),
    .clearing_o (clearing)
  );

  assign in_ready_o = (state_q == SIdle) && !clearing;

  logic [31:0] idx_nx;
  assign idx_nx = idx_q + 32'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
      n_q         <= '0;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        SIdle: begin
          if (in_valid_i && in_ready_o) begin
            item_q  <= in_item_i;
            n_q     <= '0;
            state_q <= SRead;
          end
        end
        SRead: begin
          if (bad_chan) begin
            if (out_free) begin
              out_q       <= '{out_channel: item_q.channel, grid_index: '0,
                               grid_value: '0, last: 1'b1,
                               status: plr_pkg::StatusBadChan};
              state_q     <= SIdle;
            end
          end else begin
            t0_q     <= rd_data[31:0];
            y0_q     <= rd_data[63:32];
            idx_q    <= rd_data[95:64];
            gt_q     <= rd_data[95:64] * step_q;
            state_q  <= SCheck;
          end
        end
        SCheck: begin
          if (!(gt_q <= big1) || n_q == RW'(MaxRun)) begin
            state_q <= SWrite;
          end else if (t0_q == item_q.sample_time) begin
            val_q   <= item_q.sample_value;
            state_q <= SEmit;
          end else begin
            state_q <= SLerp;
          end
        end
        SLerp: begin
          if (lerp_done) begin
            val_q   <= lerp_value;
            state_q <= SEmit;
          end
        end
        SEmit: begin
          // Decide last/truncation from the next point before the transfer
          if (out_free) begin
            logic [63:0] gt_nx;
            logic        due_nx;
            gt_nx  = idx_nx * step_q;
            due_nx = gt_nx <= big1;
            out_q.out_channel <= item_q.channel;
            out_q.grid_index  <= idx_q;
            out_q.grid_value  <= val_q;
            out_q.last        <= !due_nx || (n_q == RW'(MaxRun - 1));
            out_q.status      <= (due_nx && n_q == RW'(MaxRun - 1))
                                 ? plr_pkg::StatusTruncated : plr_pkg::StatusOk;
            idx_q             <= idx_nx;
            gt_q              <= gt_nx;
            n_q               <= n_q + RW'(1);
            state_q           <= SCheck;
          end
        end
        SWrite: state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end

  assign pt_due      = gt_q <= big1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == SIdle))
    else $error("ready outside idle");
  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= RW'(MaxRun))
    else $error("run exceeded");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> ($stable(out_q) && out_valid_q))
    else $error("result overwritten");
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !in_ready_o)
    else $error("accept during clearing");

endmodule
